### design/ptd_pkg.sv
// Package for the point-to-triangle squared distance pipeline.
// Holds the data widths, the region codes and the pipeline payload types.
// No dependencies.
package ptd_pkg;

    // coordinate and derived widths, all exact for the worst-case inputs
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int DOT_W     = SQ_W + 2;
    localparam int EDGE_W    = DOT_W + 1;
    localparam int CROSS_W   = 2 * DOT_W + 1;
    localparam int DEN_W     = CROSS_W + 2;
    localparam int NUM_W     = EDGE_W + DEN_W + 2;
    localparam int REM_W     = NUM_W - 1;
    localparam int DD_W      = DEN_W - 1;
    localparam int DIST_W    = 52;

    // multiplier digit size and latency
    localparam int MUL_CHUNK = 31;
    localparam int MUL_LAT   = 3;

    // closest feature of the triangle
    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_C  = 3'd2,
        REG_AB = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } region_t;

    // dot products carried alongside the cross-term multipliers
    typedef struct packed {
        logic signed [DOT_W-1:0]  d1;
        logic signed [DOT_W-1:0]  d2;
        logic signed [DOT_W-1:0]  d3;
        logic signed [DOT_W-1:0]  d4;
        logic signed [DOT_W-1:0]  d5;
        logic signed [DOT_W-1:0]  d6;
        logic signed [DOT_W-1:0]  ap2;
        logic signed [DOT_W-1:0]  bp2;
        logic signed [DOT_W-1:0]  cp2;
        logic signed [DOT_W-1:0]  ab2;
        logic signed [DOT_W-1:0]  ac2;
        logic signed [DOT_W-1:0]  bc2;
        logic signed [EDGE_W-1:0] e43;
        logic signed [EDGE_W-1:0] e56;
    } dots_t;

    // side data carried alongside the numerator multipliers
    typedef struct packed {
        logic signed [DEN_W-1:0] den;
        region_t                 region;
        logic                    degen;
    } side_t;

    // one stage of the long division
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DD_W-1:0]   dd;
        logic [DIST_W-1:0] q;
        logic              sat;
        logic              zero;
        region_t           region;
        logic              degen;
    } div_t;

endpackage

### design/ptd_mul.sv
// Pipelined signed multiplier built from digit products of at most 32x32 bits.
// Three register stages: digit products, row sums, final sum.
// Depends on ptd_pkg.
module ptd_mul #(
    parameter int AW = 52,
    parameter int BW = 52
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  prod
);
    import ptd_pkg::*;

    localparam int CH = MUL_CHUNK;
    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int PW = AW + BW;

    logic signed [NA*CH-1:0] a_ext;
    logic signed [NB*CH-1:0] b_ext;
    logic signed [CH:0]      a_dig [NA];
    logic signed [CH:0]      b_dig [NB];
    logic signed [2*CH+1:0]  pp_reg [NA][NB];
    logic signed [PW-1:0]    row_next [NA];
    logic signed [PW-1:0]    row_reg [NA];
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    prod_reg;

    // split operands: lower digits unsigned, top digit signed
    assign a_ext = (NA*CH)'(a);
    assign b_ext = (NB*CH)'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                a_dig[i] = {a_ext[NA*CH-1], a_ext[i*CH +: CH]};
            else
                a_dig[i] = {1'b0, a_ext[i*CH +: CH]};
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                b_dig[j] = {b_ext[NB*CH-1], b_ext[j*CH +: CH]};
            else
                b_dig[j] = {1'b0, b_ext[j*CH +: CH]};
        end
    end

    // row sums of the digit products
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) <<< (j*CH));
        end
    end

    // final sum of the rows
    always_comb
    begin
        prod_next = '0;
        for (int i = 0; i < NA; i++)
            prod_next = prod_next + (row_reg[i] <<< (i*CH));
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                    pp_reg[i][j] <= a_dig[i] * b_dig[j];
                row_reg[i] <= row_next[i];
            end
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### design/point_triangle_distance_sq.sv
// Squared distance from a query point to a triangle in 3-D, signed fixed point in, with
// the winning Voronoi feature (vertex, edge or interior) and a flag for a degenerate
// triangle. Fully pipelined: one transaction is accepted every cycle while the output is
// not stalled, passing through 14 arithmetic stages, 52 long-division stages and one output
// register. The division of the final numerator by its denominator, one quotient bit
// per stage, sets the depth. A stalled output holds the pipeline unless the last division
// stage is empty, which is then still filled. Depends on ptd_pkg and ptd_mul.
module point_triangle_distance_sq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ptd_pkg::COORD_W-1:0]  query_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]  query_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]  query_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_a_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_a_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_a_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_b_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_b_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_b_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_c_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_c_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]  vert_c_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ptd_pkg::DIST_W-1:0]          dist_sq,
    output logic [2:0]                          region,
    output logic                                degenerate
);
    import ptd_pkg::*;

    localparam int DOT_D1  = 0;
    localparam int DOT_D2  = 1;
    localparam int DOT_D3  = 2;
    localparam int DOT_D4  = 3;
    localparam int DOT_D5  = 4;
    localparam int DOT_D6  = 5;
    localparam int DOT_AP2 = 6;
    localparam int DOT_BP2 = 7;
    localparam int DOT_CP2 = 8;
    localparam int DOT_AB2 = 9;
    localparam int DOT_AC2 = 10;
    localparam int DOT_BC2 = 11;
    localparam int NDOT    = 12;
    localparam int LAST    = DIST_W - 1;

    // handshake and stage valids
    logic adv;
    logic out_free;
    logic v_diff_reg;
    logic v_prod_reg;
    logic v_dot_reg;
    logic v_xmul_reg [MUL_LAT];
    logic v_cross_reg;
    logic v_dec_reg;
    logic v_op_reg;
    logic v_nmul_reg [MUL_LAT];
    logic v_num_reg;
    logic v_prep_reg;
    logic v_div_reg [DIST_W];
    logic out_valid_reg;

    // payload
    logic signed [COORD_W-1:0] p_in [3];
    logic signed [COORD_W-1:0] a_in [3];
    logic signed [COORD_W-1:0] b_in [3];
    logic signed [COORD_W-1:0] c_in [3];
    logic signed [DIFF_W-1:0]  ab_reg [3];
    logic signed [DIFF_W-1:0]  ac_reg [3];
    logic signed [DIFF_W-1:0]  ap_reg [3];
    logic signed [DIFF_W-1:0]  bp_reg [3];
    logic signed [DIFF_W-1:0]  cp_reg [3];
    logic signed [DIFF_W-1:0]  bc_reg [3];
    logic signed [DIFF_W-1:0]  lhs [NDOT][3];
    logic signed [DIFF_W-1:0]  rhs [NDOT][3];
    logic signed [SQ_W-1:0]    prod_reg [NDOT][3];
    logic signed [DOT_W-1:0]   dot_reg [NDOT];
    dots_t                     dly_next;
    dots_t                     dly_reg [MUL_LAT];
    logic signed [2*DOT_W-1:0] m_d1d4;
    logic signed [2*DOT_W-1:0] m_d3d2;
    logic signed [2*DOT_W-1:0] m_d5d2;
    logic signed [2*DOT_W-1:0] m_d1d6;
    logic signed [2*DOT_W-1:0] m_d3d6;
    logic signed [2*DOT_W-1:0] m_d5d4;
    dots_t                     cr_dots_reg;
    logic signed [CROSS_W-1:0] vc_reg;
    logic signed [CROSS_W-1:0] vb_reg;
    logic signed [CROSS_W-1:0] va_reg;
    region_t                   dec_region_next;
    region_t                   dec_region_reg;
    dots_t                     dec_dots_reg;
    logic signed [DEN_W-1:0]   den_reg;
    logic signed [CROSS_W-1:0] dec_vb_reg;
    logic signed [CROSS_W-1:0] dec_vc_reg;
    logic signed [EDGE_W-1:0]  op_x_next, op_x_reg;
    logic signed [DEN_W-1:0]   op_y_next, op_y_reg;
    logic signed [DEN_W-1:0]   op_z_next, op_z_reg;
    logic signed [EDGE_W-1:0]  op_w_next, op_w_reg;
    logic signed [DEN_W-1:0]   op_u_next, op_u_reg;
    logic signed [EDGE_W-1:0]  op_v_next, op_v_reg;
    logic                      op_degen_next;
    region_t                   op_region_reg;
    logic                      op_degen_reg;
    side_t                     side_reg [MUL_LAT];
    logic signed [EDGE_W+DEN_W-1:0] m_xy;
    logic signed [EDGE_W+DEN_W-1:0] m_wz;
    logic signed [EDGE_W+DEN_W-1:0] m_vu;
    logic signed [NUM_W-1:0]   num_reg;
    side_t                     num_side_reg;
    div_t                      prep_next;
    div_t                      prep_reg;
    logic                      num_pos;
    logic [DD_W-1:0]           dd;
    div_t                      div_src [DIST_W];
    div_t                      div_next [DIST_W];
    div_t                      div_reg [DIST_W];
    logic [DIST_W-1:0]         out_dist_reg;
    logic [2:0]                out_region_reg;
    logic                      out_degen_reg;

    // pipeline advance: output free, or a hole in front of it
    assign out_free = !out_valid_reg || out_ready;
    assign adv      = out_free || !v_div_reg[LAST];
    assign in_ready = adv;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_diff_reg    <= 1'b0;
            v_prod_reg    <= 1'b0;
            v_dot_reg     <= 1'b0;
            v_cross_reg   <= 1'b0;
            v_dec_reg     <= 1'b0;
            v_op_reg      <= 1'b0;
            v_num_reg     <= 1'b0;
            v_prep_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MUL_LAT; i++)
            begin
                v_xmul_reg[i] <= 1'b0;
                v_nmul_reg[i] <= 1'b0;
            end
            for (int k = 0; k < DIST_W; k++)
                v_div_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v_diff_reg    <= in_valid;
                v_prod_reg    <= v_diff_reg;
                v_dot_reg     <= v_prod_reg;
                v_xmul_reg[0] <= v_dot_reg;
                for (int i = 1; i < MUL_LAT; i++)
                begin
                    v_xmul_reg[i] <= v_xmul_reg[i-1];
                    v_nmul_reg[i] <= v_nmul_reg[i-1];
                end
                v_cross_reg   <= v_xmul_reg[MUL_LAT-1];
                v_dec_reg     <= v_cross_reg;
                v_op_reg      <= v_dec_reg;
                v_nmul_reg[0] <= v_op_reg;
                v_num_reg     <= v_nmul_reg[MUL_LAT-1];
                v_prep_reg    <= v_num_reg;
                v_div_reg[0]  <= v_prep_reg;
                for (int k = 1; k < DIST_W; k++)
                    v_div_reg[k] <= v_div_reg[k-1];
            end
            if (out_free)
                out_valid_reg <= v_div_reg[LAST];
        end
    end

    // input vectors
    assign p_in = '{query_x, query_y, query_z};
    assign a_in = '{vert_a_x, vert_a_y, vert_a_z};
    assign b_in = '{vert_b_x, vert_b_y, vert_b_z};
    assign c_in = '{vert_c_x, vert_c_y, vert_c_z};

    // operand pairs of the twelve dot products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lhs[DOT_D1][i]  = ab_reg[i];  rhs[DOT_D1][i]  = ap_reg[i];
            lhs[DOT_D2][i]  = ac_reg[i];  rhs[DOT_D2][i]  = ap_reg[i];
            lhs[DOT_D3][i]  = ab_reg[i];  rhs[DOT_D3][i]  = bp_reg[i];
            lhs[DOT_D4][i]  = ac_reg[i];  rhs[DOT_D4][i]  = bp_reg[i];
            lhs[DOT_D5][i]  = ab_reg[i];  rhs[DOT_D5][i]  = cp_reg[i];
            lhs[DOT_D6][i]  = ac_reg[i];  rhs[DOT_D6][i]  = cp_reg[i];
            lhs[DOT_AP2][i] = ap_reg[i];  rhs[DOT_AP2][i] = ap_reg[i];
            lhs[DOT_BP2][i] = bp_reg[i];  rhs[DOT_BP2][i] = bp_reg[i];
            lhs[DOT_CP2][i] = cp_reg[i];  rhs[DOT_CP2][i] = cp_reg[i];
            lhs[DOT_AB2][i] = ab_reg[i];  rhs[DOT_AB2][i] = ab_reg[i];
            lhs[DOT_AC2][i] = ac_reg[i];  rhs[DOT_AC2][i] = ac_reg[i];
            lhs[DOT_BC2][i] = bc_reg[i];  rhs[DOT_BC2][i] = bc_reg[i];
        end
    end

    // pack the dot products and edge differences for the delay line
    always_comb
    begin
        dly_next.d1  = dot_reg[DOT_D1];
        dly_next.d2  = dot_reg[DOT_D2];
        dly_next.d3  = dot_reg[DOT_D3];
        dly_next.d4  = dot_reg[DOT_D4];
        dly_next.d5  = dot_reg[DOT_D5];
        dly_next.d6  = dot_reg[DOT_D6];
        dly_next.ap2 = dot_reg[DOT_AP2];
        dly_next.bp2 = dot_reg[DOT_BP2];
        dly_next.cp2 = dot_reg[DOT_CP2];
        dly_next.ab2 = dot_reg[DOT_AB2];
        dly_next.ac2 = dot_reg[DOT_AC2];
        dly_next.bc2 = dot_reg[DOT_BC2];
        dly_next.e43 = EDGE_W'(dot_reg[DOT_D4]) - EDGE_W'(dot_reg[DOT_D3]);
        dly_next.e56 = EDGE_W'(dot_reg[DOT_D5]) - EDGE_W'(dot_reg[DOT_D6]);
    end

    // cross terms of the barycentric test
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d1d4 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D1]), .b(dot_reg[DOT_D4]), .prod(m_d1d4));
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d3d2 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D3]), .b(dot_reg[DOT_D2]), .prod(m_d3d2));
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d5d2 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D5]), .b(dot_reg[DOT_D2]), .prod(m_d5d2));
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d1d6 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D1]), .b(dot_reg[DOT_D6]), .prod(m_d1d6));
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d3d6 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D3]), .b(dot_reg[DOT_D6]), .prod(m_d3d6));
    ptd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_d5d4 (
        .clk(clk), .en(adv), .a(dot_reg[DOT_D5]), .b(dot_reg[DOT_D4]), .prod(m_d5d4));

    // region decision, tests in priority order
    always_comb
    begin
        if ($signed(cr_dots_reg.d1) <= 0 && $signed(cr_dots_reg.d2) <= 0)
            dec_region_next = REG_A;
        else if ($signed(cr_dots_reg.d3) >= 0 && $signed(cr_dots_reg.e43) <= 0)
            dec_region_next = REG_B;
        else if ($signed(cr_dots_reg.d6) >= 0 && $signed(cr_dots_reg.e56) <= 0)
            dec_region_next = REG_C;
        else if (vc_reg <= 0 && $signed(cr_dots_reg.d1) >= 0
                 && $signed(cr_dots_reg.d3) <= 0)
            dec_region_next = REG_AB;
        else if (vb_reg <= 0 && $signed(cr_dots_reg.d2) >= 0
                 && $signed(cr_dots_reg.d6) <= 0)
            dec_region_next = REG_AC;
        else if (va_reg <= 0 && $signed(cr_dots_reg.e43) >= 0
                 && $signed(cr_dots_reg.e56) >= 0)
            dec_region_next = REG_BC;
        else
            dec_region_next = REG_IN;
    end

    // numerator operands: x*y - w*z - v*u, divided by y
    always_comb
    begin
        op_x_next     = EDGE_W'(dec_dots_reg.ap2);
        op_y_next     = DEN_W'(1);
        op_z_next     = '0;
        op_w_next     = '0;
        op_u_next     = '0;
        op_v_next     = '0;
        op_degen_next = 1'b0;
        case (dec_region_reg)
            REG_B:
                op_x_next = EDGE_W'(dec_dots_reg.bp2);
            REG_C:
                op_x_next = EDGE_W'(dec_dots_reg.cp2);
            REG_AB:
            begin
                if (dec_dots_reg.ab2 != '0)
                begin
                    op_y_next = DEN_W'(dec_dots_reg.ab2);
                    op_z_next = DEN_W'(dec_dots_reg.d1);
                    op_w_next = EDGE_W'(dec_dots_reg.d1);
                end
            end
            REG_AC:
            begin
                if (dec_dots_reg.ac2 != '0)
                begin
                    op_y_next = DEN_W'(dec_dots_reg.ac2);
                    op_z_next = DEN_W'(dec_dots_reg.d2);
                    op_w_next = EDGE_W'(dec_dots_reg.d2);
                end
            end
            REG_BC:
            begin
                op_x_next = EDGE_W'(dec_dots_reg.bp2);
                if (dec_dots_reg.bc2 != '0)
                begin
                    op_y_next = DEN_W'(dec_dots_reg.bc2);
                    op_z_next = DEN_W'(dec_dots_reg.e43);
                    op_w_next = dec_dots_reg.e43;
                end
            end
            REG_IN:
            begin
                if (den_reg == '0)
                    op_degen_next = 1'b1;
                else
                begin
                    op_y_next = den_reg;
                    op_z_next = DEN_W'(dec_vb_reg);
                    op_w_next = EDGE_W'(dec_dots_reg.d1);
                    op_u_next = DEN_W'(dec_vc_reg);
                    op_v_next = EDGE_W'(dec_dots_reg.d2);
                end
            end
            default:
                op_x_next = EDGE_W'(dec_dots_reg.ap2);
        endcase
    end

    // numerator products
    ptd_mul #(.AW(EDGE_W), .BW(DEN_W)) u_mul_xy (
        .clk(clk), .en(adv), .a(op_x_reg), .b(op_y_reg), .prod(m_xy));
    ptd_mul #(.AW(EDGE_W), .BW(DEN_W)) u_mul_wz (
        .clk(clk), .en(adv), .a(op_w_reg), .b(op_z_reg), .prod(m_wz));
    ptd_mul #(.AW(EDGE_W), .BW(DEN_W)) u_mul_vu (
        .clk(clk), .en(adv), .a(op_v_reg), .b(op_u_reg), .prod(m_vu));

    // divider set-up: sign of numerator, divisor guard, saturation check
    always_comb
    begin
        num_pos = !num_reg[NUM_W-1] && (num_reg != '0);
        if (!num_side_reg.den[DEN_W-1] && num_side_reg.den != '0)
            dd = num_side_reg.den[DD_W-1:0];
        else
            dd = DD_W'(1);
        prep_next.rem    = num_reg[REM_W-1:0];
        prep_next.dd     = dd;
        prep_next.q      = '0;
        prep_next.zero   = !num_pos;
        prep_next.sat    = num_reg[REM_W-1:0] >= (REM_W'(dd) << DIST_W);
        prep_next.region = num_side_reg.region;
        prep_next.degen  = num_side_reg.degen;
    end

    // long division, one quotient bit per stage
    for (genvar k = 0; k < DIST_W; k++)
    begin : g_div
        localparam int BIT = DIST_W - 1 - k;
        logic [REM_W:0] trial;

        if (k == 0)
        begin : g_first
            assign div_src[k] = prep_reg;
        end
        else
        begin : g_rest
            assign div_src[k] = div_reg[k-1];
        end

        always_comb
        begin
            div_next[k] = div_src[k];
            trial = {1'b0, div_src[k].rem} - {1'b0, REM_W'(div_src[k].dd) << BIT};
            if (!trial[REM_W])
            begin
                div_next[k].rem    = trial[REM_W-1:0];
                div_next[k].q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[k] <= div_next[k];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // edge and offset vectors
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= DIFF_W'(b_in[i]) - DIFF_W'(a_in[i]);
                ac_reg[i] <= DIFF_W'(c_in[i]) - DIFF_W'(a_in[i]);
                ap_reg[i] <= DIFF_W'(p_in[i]) - DIFF_W'(a_in[i]);
                bp_reg[i] <= DIFF_W'(p_in[i]) - DIFF_W'(b_in[i]);
                cp_reg[i] <= DIFF_W'(p_in[i]) - DIFF_W'(c_in[i]);
                bc_reg[i] <= DIFF_W'(c_in[i]) - DIFF_W'(b_in[i]);
            end
            // component products and dot sums
            for (int k = 0; k < NDOT; k++)
            begin
                for (int i = 0; i < 3; i++)
                    prod_reg[k][i] <= lhs[k][i] * rhs[k][i];
                dot_reg[k] <= DOT_W'(prod_reg[k][0]) + DOT_W'(prod_reg[k][1])
                              + DOT_W'(prod_reg[k][2]);
            end
            // delay line beside the cross-term multipliers
            dly_reg[0] <= dly_next;
            for (int i = 1; i < MUL_LAT; i++)
                dly_reg[i] <= dly_reg[i-1];
            // cross terms
            cr_dots_reg <= dly_reg[MUL_LAT-1];
            vc_reg      <= CROSS_W'(m_d1d4) - CROSS_W'(m_d3d2);
            vb_reg      <= CROSS_W'(m_d5d2) - CROSS_W'(m_d1d6);
            va_reg      <= CROSS_W'(m_d3d6) - CROSS_W'(m_d5d4);
            // region and interior denominator
            dec_region_reg <= dec_region_next;
            dec_dots_reg   <= cr_dots_reg;
            den_reg        <= DEN_W'(va_reg) + DEN_W'(vb_reg) + DEN_W'(vc_reg);
            dec_vb_reg     <= vb_reg;
            dec_vc_reg     <= vc_reg;
            // numerator operands
            op_x_reg      <= op_x_next;
            op_y_reg      <= op_y_next;
            op_z_reg      <= op_z_next;
            op_w_reg      <= op_w_next;
            op_u_reg      <= op_u_next;
            op_v_reg      <= op_v_next;
            op_region_reg <= dec_region_reg;
            op_degen_reg  <= op_degen_next;
            // side data beside the numerator multipliers
            side_reg[0].den    <= op_y_reg;
            side_reg[0].region <= op_region_reg;
            side_reg[0].degen  <= op_degen_reg;
            for (int i = 1; i < MUL_LAT; i++)
                side_reg[i] <= side_reg[i-1];
            // numerator
            num_reg      <= NUM_W'(m_xy) - NUM_W'(m_wz) - NUM_W'(m_vu);
            num_side_reg <= side_reg[MUL_LAT-1];
            prep_reg     <= prep_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (div_reg[LAST].zero)
                out_dist_reg <= '0;
            else if (div_reg[LAST].sat)
                out_dist_reg <= '1;
            else
                out_dist_reg <= div_reg[LAST].q;
            out_region_reg <= div_reg[LAST].region;
            out_degen_reg  <= div_reg[LAST].degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dist_sq    = out_dist_reg;
    assign region     = out_region_reg;
    assign degenerate = out_degen_reg;

    // a degenerate flag only comes with the interior region
    a_degen_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_degen_reg |-> out_region_reg == REG_IN)
        else $error("degenerate flag outside interior region");

    // the last division stage holds while the output is blocked
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && v_div_reg[LAST]
        |=> v_div_reg[LAST] && $stable(div_reg[LAST].q))
        else $error("division result lost during stall");

    // vertex regions divide by one
    a_vertex_unit: assert property (@(posedge clk) disable iff (!rst_n)
        v_prep_reg && (prep_reg.region == REG_A || prep_reg.region == REG_B
                       || prep_reg.region == REG_C)
        |-> prep_reg.dd == DD_W'(1))
        else $error("vertex region with divisor other than one");

    // final remainder below the divisor in the normal case
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_div_reg[LAST] && !div_reg[LAST].sat && !div_reg[LAST].zero
        |-> div_reg[LAST].rem < REM_W'(div_reg[LAST].dd))
        else $error("division remainder not below divisor");

endmodule
